// File: src/ascii_integer_scanner_core_defines.svh
// Assertion macros used by the integer scanner RTL.
`ifndef ASCII_INTEGER_SCANNER_CORE_DEFINES_SVH
`define ASCII_INTEGER_SCANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge while reset is released.
`define AIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define AIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define AIS_ASSERT(lbl, prop, msg)
`define AIS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/ais_pkg.sv
// Types and constants of the integer scanner.
`default_nettype none
package ais_pkg;

  localparam int BufferSize = 40;
  // Longest number field in characters.
  localparam logic [5:0] WidthTop = 6'(BufferSize - 1);

  // Conversion modes.
  localparam logic [2:0] ModeAutoSigned = 3'd0;
  localparam logic [2:0] ModeOctUnsigned = 3'd1;
  localparam logic [2:0] ModeDecSigned = 3'd2;
  localparam logic [2:0] ModeDecUnsigned = 3'd3;
  localparam logic [2:0] ModeHexUnsigned = 3'd4;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegConvMode = 2'd0;
  localparam logic [1:0] RegMaxWidth = 2'd1;
  localparam logic [1:0] RegShortResult = 2'd2;

  // Result status codes.
  localparam logic [1:0] StatusConverted = 2'd0;
  localparam logic [1:0] StatusMatchFail = 2'd1;
  localparam logic [1:0] StatusNoField = 2'd2;

  // Number bases; zero means not yet decided (automatic mode).
  localparam logic [4:0] BaseAuto = 5'd0;
  localparam logic [4:0] BaseOct = 5'd8;
  localparam logic [4:0] BaseDec = 5'd10;
  localparam logic [4:0] BaseHex = 5'd16;

  typedef struct packed {
    logic [2:0] conv_mode;
    logic [5:0] max_width;
    logic       short_result;
  } cfg_t;

  typedef struct packed {
    logic        in_number;
    logic        sign_ok;
    logic        no_digits;
    logic        pfx_ok;
    logic        nz_digits;
    logic [4:0]  base;
    logic [31:0] magnitude;
    logic        overflowed;
    logic        is_negative;
    logic [5:0]  char_count;
    logic        last_was_x;
  } state_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [5:0]  used_count;
    logic        gave_back;
    logic        stopper_taken;
  } result_t;

  // Scan state after reset: decimal signed mode, skipping whitespace.
  localparam state_t ResetState = '{
    in_number:   1'b0,
    sign_ok:     1'b1,
    no_digits:   1'b1,
    pfx_ok:      1'b0,
    nz_digits:   1'b1,
    base:        BaseDec,
    magnitude:   32'd0,
    overflowed:  1'b0,
    is_negative: 1'b0,
    char_count:  6'd0,
    last_was_x:  1'b0
  };

endpackage
`default_nettype wire

// File: src/ais_if.sv
// Stream interfaces for character words in and result words out.
`default_nettype none
interface ais_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       at_end;

  modport source (output valid, output char_code, output at_end, input ready);
  modport sink (input valid, input char_code, input at_end, output ready);
endinterface

interface ais_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  status;
  logic [5:0]  used_count;
  logic        gave_back;
  logic        stopper_taken;

  modport source (output valid, output value, output status, output used_count,
                  output gave_back, output stopper_taken, input ready);
  modport sink (input valid, input value, input status, input used_count,
                input gave_back, input stopper_taken, output ready);
endinterface
`default_nettype wire

// File: src/ais_cfg_regs.sv
// Configuration registers of the integer scanner.
`default_nettype none
module ais_cfg_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [5:0]  cfg_wdata_i,
  output ais_pkg::cfg_t    cfg_o
);

  ais_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ais_pkg::RegConvMode:    cfg_d.conv_mode = cfg_wdata_i[2:0];
        ais_pkg::RegMaxWidth:    cfg_d.max_width = cfg_wdata_i;
        ais_pkg::RegShortResult: cfg_d.short_result = cfg_wdata_i[0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conv_mode <= ais_pkg::ModeDecSigned;
      cfg_q.max_width <= 6'd0;
      cfg_q.short_result <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: src/ais_step.sv
// Next-state and result logic for one character of the integer scanner.
`default_nettype none
module ais_step (
  input  wire ais_pkg::cfg_t   cfg_i,
  input  wire ais_pkg::state_t state_i,
  input  wire logic [7:0]      char_code_i,
  input  wire logic            at_end_i,
  output ais_pkg::state_t      state_o,
  output logic                 emit_o,
  output ais_pkg::result_t     result_o
);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChOne = 8'h31;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpF = 8'h46;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChUpX = 8'h58;
  localparam logic [7:0] ChLowX = 8'h78;

  function automatic logic mode_unsigned(input logic [2:0] mode);
    return mode == ais_pkg::ModeOctUnsigned || mode == ais_pkg::ModeDecUnsigned ||
           mode == ais_pkg::ModeHexUnsigned;
  endfunction

  function automatic logic [31:0] mag_limit(input logic uns, input logic neg);
    logic [31:0] lim;
    if (uns) lim = 32'hFFFF_FFFF;
    else if (neg) lim = 32'h8000_0000;
    else lim = 32'h7FFF_FFFF;
    return lim;
  endfunction

  // Fresh field state; base and prefix permission follow the mode.
  function automatic ais_pkg::state_t load_state(input logic [2:0] mode);
    ais_pkg::state_t s;
    s = ais_pkg::ResetState;
    unique case (mode)
      ais_pkg::ModeAutoSigned:  s.base = ais_pkg::BaseAuto;
      ais_pkg::ModeOctUnsigned: s.base = ais_pkg::BaseOct;
      ais_pkg::ModeHexUnsigned: begin
        s.base = ais_pkg::BaseHex;
        s.pfx_ok = 1'b1;
      end
      default:                  s.base = ais_pkg::BaseDec;
    endcase
    return s;
  endfunction

  ais_pkg::state_t  eff;
  ais_pkg::state_t  work;
  ais_pkg::state_t  fin_src;
  ais_pkg::result_t fin;
  logic             ok;
  logic             xch;
  logic             dig_en;
  logic [3:0]       dig;
  logic [35:0]      prod;
  logic [35:0]      acc;
  logic [31:0]      lim;
  logic [31:0]      fin_lim;
  logic             fin_ovf;
  logic             fin_uns;
  logic [5:0]       width_lim;
  logic             is_space;
  logic             at_limit;
  logic             taken;

  always_comb begin
    is_space = char_code_i == ChSpace || (char_code_i >= ChTab && char_code_i <= ChCr);
    eff = state_i.in_number ? state_i : load_state(cfg_i.conv_mode);
    work = eff;
    ok = 1'b0;
    xch = 1'b0;
    dig_en = 1'b0;
    dig = 4'd0;

    if (char_code_i == ChZero) begin
      if (work.base == ais_pkg::BaseAuto) begin
        work.base = ais_pkg::BaseOct;
        work.pfx_ok = 1'b1;
      end
      // A leading zero keeps the prefix open; a later zero closes it.
      if (work.nz_digits) begin
        work.nz_digits = 1'b0;
      end else begin
        work.pfx_ok = 1'b0;
      end
      work.sign_ok = 1'b0;
      work.no_digits = 1'b0;
      dig_en = 1'b1;
      ok = 1'b1;
    end else if (char_code_i >= ChOne && char_code_i <= ChNine) begin
      if (work.base == ais_pkg::BaseAuto) work.base = ais_pkg::BaseDec;
      if (char_code_i <= ChSeven || work.base > ais_pkg::BaseOct) begin
        work.sign_ok = 1'b0;
        work.pfx_ok = 1'b0;
        work.no_digits = 1'b0;
        dig_en = 1'b1;
        dig = char_code_i[3:0];
        ok = 1'b1;
      end
    end else if ((char_code_i >= ChLowA && char_code_i <= ChLowF) ||
                 (char_code_i >= ChUpA && char_code_i <= ChUpF)) begin
      if (work.base > ais_pkg::BaseDec) begin
        work.sign_ok = 1'b0;
        work.pfx_ok = 1'b0;
        work.no_digits = 1'b0;
        dig_en = 1'b1;
        // Letters a to f have low nibbles 1 to 6.
        dig = char_code_i[3:0] + 4'd9;
        ok = 1'b1;
      end
    end else if (char_code_i == ChPlus || char_code_i == ChMinus) begin
      if (work.sign_ok) begin
        work.sign_ok = 1'b0;
        work.is_negative = char_code_i == ChMinus;
        ok = 1'b1;
      end
    end else if (char_code_i == ChLowX || char_code_i == ChUpX) begin
      if (work.pfx_ok && work.char_count == 6'd1) begin
        work.base = ais_pkg::BaseHex;
        work.pfx_ok = 1'b0;
        ok = 1'b1;
        xch = 1'b1;
      end
    end

    // Multiply-add by shifts: base is 8, 10 or 16 whenever a digit is taken.
    if (work.base == ais_pkg::BaseHex) prod = {work.magnitude, 4'd0};
    else if (work.base == ais_pkg::BaseOct) prod = {1'b0, work.magnitude, 3'd0};
    else prod = {1'b0, work.magnitude, 3'd0} + {3'd0, work.magnitude, 1'b0};
    acc = prod + {32'd0, dig};
    lim = mag_limit(mode_unsigned(cfg_i.conv_mode), work.is_negative);
    if (dig_en && !work.overflowed) begin
      if (acc > {4'd0, lim}) begin
        work.overflowed = 1'b1;
        work.magnitude = lim;
      end else begin
        work.magnitude = acc[31:0];
      end
    end

    work.char_count = work.char_count + 6'd1;
    work.last_was_x = xch;
    work.in_number = 1'b1;

    width_lim = (cfg_i.max_width == 6'd0 || cfg_i.max_width > ais_pkg::WidthTop) ?
                ais_pkg::WidthTop : cfg_i.max_width;
    at_limit = work.char_count >= width_lim;

    // Closing the field: from the updated state when the character was taken.
    taken = ok && !at_end_i;
    fin_src = taken ? work : eff;
    fin_uns = mode_unsigned(cfg_i.conv_mode);
    fin_lim = mag_limit(fin_uns, fin_src.is_negative);
    fin_ovf = fin_src.overflowed || fin_src.magnitude > fin_lim;
    fin.value = 32'd0;
    fin.status = ais_pkg::StatusMatchFail;
    fin.used_count = 6'd0;
    fin.gave_back = |fin_src.char_count;
    fin.stopper_taken = taken;
    if (!fin_src.no_digits) begin
      fin.gave_back = fin_src.last_was_x;
      fin.used_count = fin_src.char_count - {5'd0, fin_src.last_was_x};
      fin.status = ais_pkg::StatusConverted;
      if (fin_ovf) fin.value = fin_uns ? 32'hFFFF_FFFF : fin_lim;
      else if (fin_src.is_negative) fin.value = 32'd0 - fin_src.magnitude;
      else fin.value = fin_src.magnitude;
      if (cfg_i.short_result) fin.value = {16'd0, fin.value[15:0]};
    end

    emit_o = 1'b0;
    state_o = state_i;
    result_o = fin;
    priority if (!state_i.in_number && at_end_i) begin
      emit_o = 1'b1;
      result_o = '{value: 32'd0, status: ais_pkg::StatusNoField, used_count: 6'd0,
                   gave_back: 1'b0, stopper_taken: 1'b0};
      state_o = load_state(cfg_i.conv_mode);
    end else if (!state_i.in_number && is_space) begin
      state_o = state_i;
    end else if (at_end_i || !ok || at_limit) begin
      emit_o = 1'b1;
      state_o = load_state(cfg_i.conv_mode);
    end else begin
      state_o = work;
    end
  end

endmodule
`default_nettype wire

// File: src/ascii_integer_scanner_core.sv
// Top level of the scanf-style integer scanner.
// A character word accepted into the input register is processed by the step stage,
// and a result it closes is registered in the result register and offered on the output.
// Throughput: one character word per cycle while the result register is free to take a result.
// Reset: asynchronous, active low; the scanner skips whitespace in decimal signed mode.
// No clearing pass is needed after reset.
`default_nettype none
`include "ascii_integer_scanner_core_defines.svh"
module ascii_integer_scanner_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ais_char_if.sink         in_i,
  ais_result_if.source     out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [5:0]  cfg_wdata_i
);

  ais_pkg::cfg_t    cfg;
  ais_pkg::state_t  state_q, state_d;
  ais_pkg::result_t step_res;
  ais_pkg::result_t out_data_q;
  logic             step_emit;

  // Input register: holds one accepted character word until the step stage takes it.
  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_end_q;

  logic out_valid_q;
  logic out_free;
  logic s1_fire;
  logic in_acc;

  ais_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The result register is free when empty or when its word leaves this cycle,
  // so the step stage never waits on an idle output.
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire = s1_valid_q && out_free;
  // The input register refills in the same cycle it empties.
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_acc = in_i.valid && in_i.ready;

  ais_step u_step (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .char_code_i (s1_char_q),
    .at_end_i    (s1_end_q),
    .state_o     (state_d),
    .emit_o      (step_emit),
    .result_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q <= ais_pkg::ResetState;
    end else begin
      if (in_acc) s1_valid_q <= 1'b1;
      else if (s1_fire) s1_valid_q <= 1'b0;

      if (s1_fire) state_q <= state_d;

      if (s1_fire && step_emit) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q <= in_i.char_code;
      s1_end_q <= in_i.at_end;
    end
    if (s1_fire && step_emit) out_data_q <= step_res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = out_data_q.value;
  assign out_o.status = out_data_q.status;
  assign out_o.used_count = out_data_q.used_count;
  assign out_o.gave_back = out_data_q.gave_back;
  assign out_o.stopper_taken = out_data_q.stopper_taken;

  // Between fields the state is always freshly loaded.
  `AIS_ASSERT(a_idle_clear, !state_q.in_number |-> state_q.char_count == '0, "idle count set")
  // A field closes as soon as it reaches the width limit.
  `AIS_ASSERT(a_count_below_top, state_q.char_count < ais_pkg::WidthTop, "count at limit")
  // A word taken by the step stage without a refill leaves the input register empty.
  `AIS_ASSERT(a_s1_drains, (s1_fire && !in_acc) |=> !s1_valid_q, "input word kept")
  // A result word that is not taken stays offered.
  `AIS_ASSERT(a_out_held, out_valid_q && !out_o.ready |=> out_valid_q, "result word dropped")

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the scanf-style integer scanner core.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] TabCode = 8'h09;
  localparam logic [7:0] CrCode = 8'h0D;
  localparam int unsigned WordTarget = 1700;

  // Tracks the scanner's field state and holds the result words still owed by the block.
  class scan_scoreboard;
    logic [2:0]  mode;
    logic [5:0]  width_cfg;
    logic        short_cfg;
    logic        in_num;
    logic        sign_ok;
    logic        no_dig;
    logic        pfx_ok;
    logic        nz_dig;
    logic [4:0]  base;
    logic [31:0] mag;
    logic        ovf;
    logic        neg;
    logic [5:0]  cnt;
    logic        last_x;
    ais_pkg::result_t owed_q[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned words_seen;
    int unsigned words_skipped;
    int unsigned status_hits[3];
    int unsigned width_stops;
    int unsigned saturations;

    function new();
      mode = ais_pkg::ModeDecSigned;
      width_cfg = '0;
      short_cfg = 1'b0;
      in_num = 1'b0;
      mismatches = 0;
      results_seen = 0;
      words_seen = 0;
      words_skipped = 0;
      status_hits = '{0, 0, 0};
      width_stops = 0;
      saturations = 0;
      start_field();
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [5:0] data);
      case (idx)
        ais_pkg::RegConvMode: mode = data[2:0];
        ais_pkg::RegMaxWidth: width_cfg = data;
        ais_pkg::RegShortResult: short_cfg = data[0];
        default: ;
      endcase
    endfunction

    function bit unsigned_mode();
      return mode == ais_pkg::ModeOctUnsigned || mode == ais_pkg::ModeDecUnsigned ||
             mode == ais_pkg::ModeHexUnsigned;
    endfunction

    function logic [31:0] mag_cap();
      if (unsigned_mode()) return 32'hFFFF_FFFF;
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function logic [5:0] width_cap();
      if (width_cfg == '0 || width_cfg > ais_pkg::WidthTop) return ais_pkg::WidthTop;
      return width_cfg;
    endfunction

    // Base and prefix permission are taken from the mode at the start of each field.
    function void start_field();
      sign_ok = 1'b1;
      no_dig = 1'b1;
      nz_dig = 1'b1;
      pfx_ok = 1'b0;
      case (mode)
        ais_pkg::ModeAutoSigned: base = ais_pkg::BaseAuto;
        ais_pkg::ModeOctUnsigned: base = ais_pkg::BaseOct;
        ais_pkg::ModeHexUnsigned: begin
          base = ais_pkg::BaseHex;
          pfx_ok = 1'b1;
        end
        default: base = ais_pkg::BaseDec;
      endcase
      mag = '0;
      ovf = 1'b0;
      neg = 1'b0;
      cnt = '0;
      last_x = 1'b0;
    endfunction

    function void add_digit(logic [4:0] d);
      logic [63:0] t;
      logic [31:0] cap;
      cap = mag_cap();
      if (ovf) return;
      t = 64'(mag) * 64'(base) + 64'(d);
      if (t > 64'(cap)) begin
        ovf = 1'b1;
        mag = cap;
      end else begin
        mag = t[31:0];
      end
    endfunction

    function void close_field(logic taken);
      ais_pkg::result_t r;
      logic [31:0] cap;
      r = '0;
      r.status = ais_pkg::StatusMatchFail;
      if (no_dig) begin
        r.gave_back = (cnt != '0);
      end else begin
        cap = mag_cap();
        r.gave_back = last_x;
        r.used_count = cnt - 6'(last_x);
        r.status = ais_pkg::StatusConverted;
        if (ovf || mag > cap) begin
          r.value = unsigned_mode() ? 32'hFFFF_FFFF : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
          saturations++;
        end else begin
          r.value = neg ? 32'd0 - mag : mag;
        end
        if (short_cfg) r.value[31:16] = '0;
      end
      r.stopper_taken = taken;
      if (taken) width_stops++;
      status_hits[r.status]++;
      owed_q.push_back(r);
      in_num = 1'b0;
      start_field();
    endfunction

    // Called for every character word the block accepts.
    function void note_char(logic [7:0] c, logic e);
      logic ok;
      logic xch;
      ais_pkg::result_t r;
      ok = 1'b0;
      xch = 1'b0;
      words_seen++;
      if (!in_num) begin
        if (e) begin
          r = '0;
          r.status = ais_pkg::StatusNoField;
          status_hits[ais_pkg::StatusNoField]++;
          owed_q.push_back(r);
          start_field();
          return;
        end
        if (c == " " || (c >= TabCode && c <= CrCode)) begin
          words_skipped++;
          return;
        end
        start_field();
        in_num = 1'b1;
      end
      if (e) begin
        close_field(1'b0);
        return;
      end
      if (c == "0") begin
        if (base == ais_pkg::BaseAuto) begin
          base = ais_pkg::BaseOct;
          pfx_ok = 1'b1;
        end
        if (nz_dig) begin
          sign_ok = 1'b0;
          nz_dig = 1'b0;
          no_dig = 1'b0;
        end else begin
          sign_ok = 1'b0;
          pfx_ok = 1'b0;
          no_dig = 1'b0;
        end
        add_digit(5'd0);
        ok = 1'b1;
      end else if (c >= "1" && c <= "9") begin
        if (base == ais_pkg::BaseAuto) base = ais_pkg::BaseDec;
        if (c <= "7" || base > ais_pkg::BaseOct) begin
          sign_ok = 1'b0;
          pfx_ok = 1'b0;
          no_dig = 1'b0;
          add_digit(5'(c - "0"));
          ok = 1'b1;
        end
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
        if (base > ais_pkg::BaseDec) begin
          sign_ok = 1'b0;
          pfx_ok = 1'b0;
          no_dig = 1'b0;
          add_digit((c >= "a") ? 5'(c - "a" + 8'd10) : 5'(c - "A" + 8'd10));
          ok = 1'b1;
        end
      end else if (c == "+" || c == "-") begin
        if (sign_ok) begin
          sign_ok = 1'b0;
          neg = (c == "-");
          ok = 1'b1;
        end
      end else if (c == "x" || c == "X") begin
        if (pfx_ok && cnt == 6'd1) begin
          base = ais_pkg::BaseHex;
          pfx_ok = 1'b0;
          ok = 1'b1;
          xch = 1'b1;
        end
      end
      if (!ok) begin
        close_field(1'b0);
        return;
      end
      cnt = cnt + 6'd1;
      last_x = xch;
      if (cnt >= width_cap()) close_field(1'b1);
    endfunction

    function string fmt(ais_pkg::result_t r);
      return $sformatf("value=%h status=%0d used=%0d gave_back=%0b taken=%0b",
                       r.value, r.status, r.used_count, r.gave_back, r.stopper_taken);
    endfunction

    function void note_mismatch(string msg);
      if (mismatches < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    // Called for every result word the block hands over.
    function void check_result(ais_pkg::result_t got);
      ais_pkg::result_t want;
      string bad;
      results_seen++;
      if (owed_q.size() == 0) begin
        note_mismatch({"result with none expected: ", fmt(got)});
        return;
      end
      want = owed_q.pop_front();
      bad = "";
      if (got.value !== want.value) bad = {bad, " value"};
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.used_count !== want.used_count) bad = {bad, " used_count"};
      if (got.gave_back !== want.gave_back) bad = {bad, " gave_back"};
      if (got.stopper_taken !== want.stopper_taken) bad = {bad, " stopper_taken"};
      if (bad != "") begin
        note_mismatch($sformatf("result %0d differs in%s; expected %s, got %s",
                                results_seen, bad, fmt(want), fmt(got)));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [5:0] cfg_wdata_i;
  // While set, neither side inserts idle cycles.
  bit calm;
  scan_scoreboard sb;

  ais_char_if in_if ();
  ais_result_if out_if ();

  ascii_integer_scanner_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The result side stalls now and then; ready changes only on the falling edge.
  always @(negedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(0, 99) >= 6);
  end

  // Every result word taken at a rising edge goes straight to the scoreboard.
  always @(posedge clk_i) begin
    ais_pkg::result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.value = out_if.value;
      got.status = out_if.status;
      got.used_count = out_if.used_count;
      got.gave_back = out_if.gave_back;
      got.stopper_taken = out_if.stopper_taken;
      sb.check_result(got);
    end
  end

  // Offers one character word, with an occasional idle gap first, and returns on the
  // falling edge after it was taken. Valid stays high so back-to-back words need no gap.
  task automatic send_word(logic [7:0] c, logic e);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_if.valid <= 1'b0;
      in_if.char_code <= 8'($urandom);
      in_if.at_end <= 1'($urandom);
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.char_code <= c;
    in_if.at_end <= e;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_char(c, e);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // Holds the sender until every owed result has arrived. A word that closes no field
  // may still be in the step stage, so the task keeps waiting on the clock to let it drain.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes all three registers on consecutive edges; call only after drain.
  task automatic set_config(logic [2:0] mode, logic [5:0] width, logic short_res);
    logic [5:0] mode_word;
    logic [5:0] short_word;
    mode_word = {3'($urandom), mode};
    short_word = {5'($urandom), short_res};
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ais_pkg::RegConvMode;
    cfg_wdata_i <= mode_word;
    sb.write_reg(ais_pkg::RegConvMode, mode_word);
    @(negedge clk_i);
    cfg_idx_i <= ais_pkg::RegMaxWidth;
    cfg_wdata_i <= width;
    sb.write_reg(ais_pkg::RegMaxWidth, width);
    @(negedge clk_i);
    cfg_idx_i <= ais_pkg::RegShortResult;
    cfg_wdata_i <= short_word;
    sb.write_reg(ais_pkg::RegShortResult, short_word);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_space();
    if ($urandom_range(0, 2) == 0) return " ";
    return TabCode + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] pick_digit(int radix);
    int v;
    v = $urandom_range(0, radix - 1);
    if (v < 10) return "0" + 8'(v);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 10);
  endfunction

  // One well-formed field with random content, or a short burst of noise.
  // Digits are drawn from some base that need not match the mode, so fields
  // also end on a digit that the current base rejects.
  task automatic gen_field();
    int pick;
    int radix;
    int n_dig;
    repeat ($urandom_range(0, 2)) send_word(pick_space(), 1'b0);
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 4)) send_word(8'($urandom), 1'($urandom_range(0, 9) == 0));
      return;
    end
    if ($urandom_range(0, 99) < 40) send_word($urandom_range(0, 1) ? "-" : "+", 1'b0);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_word("0", 1'b0);
      send_word($urandom_range(0, 1) ? "x" : "X", 1'b0);
    end else if (pick < 40) begin
      send_word("0", 1'b0);
    end
    pick = $urandom_range(0, 99);
    radix = (pick < 35) ? 16 : (pick < 70) ? 10 : 8;
    pick = $urandom_range(0, 99);
    if (pick < 5) n_dig = 0;
    else if (pick < 85) n_dig = $urandom_range(1, 6);
    else if (pick < 95) n_dig = $urandom_range(7, 12);
    else n_dig = $urandom_range(13, 45);
    repeat (n_dig) send_word(pick_digit(radix), 1'b0);
    pick = $urandom_range(0, 99);
    if (pick < 35) send_word(pick_space(), 1'b0);
    else if (pick < 47) send_word(8'($urandom), 1'b1);
    else if (pick < 72) send_word(8'($urandom), 1'b0);
  endtask

  // Directed words first, then random phases, each under a fresh register setting.
  initial begin
    int unsigned phase;
    int unsigned next_phase_at;
    logic [5:0] width_pick;
    logic [5:0] first_widths[6];
    first_widths = '{6'd0, 6'd63, 6'd1, 6'd39, 6'd40, 6'd2};
    sb = new();
    calm = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.char_code = '0;
    in_if.at_end = 1'b0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ais_pkg::RegConvMode;
    cfg_wdata_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset setting, decimal signed: end of input before any field, a lone sign,
    // a plain negative number closed by a space, and a rejected first character.
    send_word(8'($urandom), 1'b1);
    send_text("+q-42 q");
    drain();
    // Hex: sign and x with no digits, then a mixed-case prefixed number.
    set_config(ais_pkg::ModeHexUnsigned, 6'd0, 1'b0);
    send_text("-x");
    send_word(8'($urandom), 1'b1);
    send_text("0xfF;");
    drain();
    // Automatic base: a trailing x that is given back, then an octal number.
    set_config(ais_pkg::ModeAutoSigned, 6'd0, 1'b0);
    send_text("0x!017 ");
    drain();
    // Width of two stops the field on an accepted digit; short result keeps 16 bits.
    set_config(ais_pkg::ModeDecUnsigned, 6'd2, 1'b1);
    send_text("-9");
    drain();

    phase = 0;
    next_phase_at = 0;
    while (sb.words_seen < WordTarget) begin
      if (sb.words_seen >= next_phase_at) begin
        // Registers change only between phases, with nothing in flight. A field
        // may still be open, which exercises settings that are read live.
        drain();
        if (phase < 6) begin
          width_pick = first_widths[phase];
        end else begin
          case ($urandom_range(0, 4))
            0: width_pick = 6'd0;
            1: width_pick = 6'($urandom_range(1, 3));
            2: width_pick = 6'($urandom_range(39, 63));
            default: width_pick = 6'($urandom_range(4, 38));
          endcase
        end
        set_config((phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7)), width_pick,
                   (phase < 2) ? 1'(phase) : 1'($urandom));
        phase++;
        next_phase_at = sb.words_seen + $urandom_range(80, 220);
      end
      calm = (sb.words_seen >= 700) && (sb.words_seen < 1050);
      gen_field();
      if ($urandom_range(0, 39) == 0) drain();
    end
    calm = 1'b0;
    drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d character words (%0d skipped as whitespace) over %0d settings.",
             sb.words_seen, sb.words_skipped, phase + 4);
    $display("Checked %0d results: %0d converted, %0d match failures, %0d ended early,",
             sb.results_seen, sb.status_hits[ais_pkg::StatusConverted],
             sb.status_hits[ais_pkg::StatusMatchFail], sb.status_hits[ais_pkg::StatusNoField]);
    $display("  %0d saturated, %0d width stops.", sb.saturations, sb.width_stops);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** ascii_integer_scanner_core: PASSED **");
    end else begin
      $display("%0d mismatches found.", sb.mismatches);
      $display("** ascii_integer_scanner_core: FAILED **");
    end
    $finish;
  end

  // Generous bound on the whole run; a hang in either handshake ends here.
  initial begin
    #20_000_000;
    $display("Timeout with %0d results still owed.", sb.pending());
    $display("** ascii_integer_scanner_core: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
